[hw/rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared sizes, command codes and the request type of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int BUCKETS    = 64;
  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // The free-slot search runs in two steps: first a group, then a bit in it.
  localparam int GRP_W     = 16;
  localparam int BIT_W     = $clog2(GRP_W);
  localparam int N_GRP     = (CAPACITY + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W = (N_GRP > 1) ? $clog2(N_GRP) : 1;
  localparam int PAD_W     = N_GRP * GRP_W;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [BKT_W-1:0]      bucket;
  } req_t;

endpackage

[hw/rtl/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Accepts command transactions, derives the bucket and queues the requests.
// ----------------------------------------------------------------------------
module chm_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_cmd,
  input  logic [31:0]              in_key,
  input  logic [31:0]              in_value,
  output chm_pkg::req_t            req,
  output logic                     req_valid,
  input  logic                     req_pop
);
  import chm_pkg::*;

  req_t             q_r [QDEPTH];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;
  logic [1:0]       fill_nxt;
  logic             push;
  req_t             new_req;

  assign in_stall  = (fill_r == 2'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign req_valid = (fill_r != 2'd0);
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    new_req.cmd    = cmd_t'(in_cmd);
    new_req.key    = in_key[KEY_BITS-1:0];
    new_req.value  = in_value[VALUE_BITS-1:0];
    // The bucket count is a power of two, so the modulo is the low key bits.
    new_req.bucket = in_key[BKT_W-1:0];
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !(req_pop && req_valid)) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && req_pop && req_valid) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (req_pop && req_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'(QDEPTH)) else $error("queue fill above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> req_valid) else $error("pop from an empty queue");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with fill");

endmodule

[hw/rtl/chm_engine.sv]
// ----------------------------------------------------------------------------
// chm_engine
// Walks bucket chains in memory, executes commands and registers the result.
// ----------------------------------------------------------------------------
module chm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  chm_pkg::req_t       req,
  input  logic                req_valid,
  output logic                req_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [31:0]         out_found_value,
  output logic [8:0]          out_count
);
  import chm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_CMP   = 6'b000100,
    S_MISS  = 6'b001000,
    S_GRP   = 6'b010000,
    S_ALLOC = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;

  // Memories.
  logic [SLOT_W-1:0]     head_mem [BUCKETS];
  logic [KEY_BITS-1:0]   key_mem  [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0]     nxt_mem  [CAPACITY];

  logic [SLOT_W-1:0]     head_rd_r;
  logic [KEY_BITS-1:0]   key_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;
  logic [SLOT_W-1:0]     nxt_rd_r;

  // Flag bits cleared by reset and by a clear command.
  logic [BUCKETS-1:0]    head_valid_r;
  logic [CAPACITY-1:0]   slot_used_r;
  logic [CAPACITY-1:0]   next_valid_r;
  logic [CNT_W-1:0]      count_r, count_nxt;

  // Current request.
  cmd_t                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [BKT_W-1:0]      bkt_r;
  logic [SLOT_W-1:0]     head_r;
  logic                  head_v_r;
  logic [SLOT_W-1:0]     cur_r;
  logic [SLOT_W-1:0]     prev_r;
  logic                  has_prev_r;
  logic [GRP_IDX_W-1:0]  grp_r;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [VALUE_BITS-1:0] out_found_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  start;
  logic                  do_clear;
  logic                  done;
  logic                  res_ok;
  logic [VALUE_BITS-1:0] res_found;
  logic                  match;
  logic                  nv_cur;
  logic [SLOT_W-1:0]     slot_raddr;

  logic [PAD_W-1:0]      used_pad;
  logic [N_GRP-1:0]      grp_full;
  logic [GRP_IDX_W-1:0]  grp_sel;
  logic                  grp_any;
  logic [GRP_W-1:0]      grp_bits;
  logic [BIT_W-1:0]      bit_sel;
  logic [SLOT_W-1:0]     alloc_slot;

  // Write ports.
  logic                  head_we;
  logic [BKT_W-1:0]      head_waddr;
  logic [SLOT_W-1:0]     head_wdata;
  logic                  key_we;
  logic                  val_we;
  logic [SLOT_W-1:0]     val_waddr;
  logic                  nxt_we;
  logic [SLOT_W-1:0]     nxt_waddr;
  logic [SLOT_W-1:0]     nxt_wdata;

  assign start    = (state_r == S_IDLE) && req_valid && !out_valid_r;
  assign req_pop  = start;
  assign do_clear = start && (req.cmd == CMD_CLEAR);
  assign match    = (key_rd_r == key_r);
  assign nv_cur   = next_valid_r[cur_r];

  always_comb begin
    for (int i = 0; i < PAD_W; i++) begin
      used_pad[i] = (i < CAPACITY) ? slot_used_r[i] : 1'b1;
    end
    for (int g = 0; g < N_GRP; g++) begin
      grp_full[g] = &used_pad[g*GRP_W +: GRP_W];
    end
    grp_sel = '0;
    grp_any = 1'b0;
    for (int g = N_GRP - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        grp_sel = GRP_IDX_W'(g);
        grp_any = 1'b1;
      end
    end
    grp_bits = used_pad[grp_r*GRP_W +: GRP_W];
    bit_sel  = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
    alloc_slot = SLOT_W'({grp_r, bit_sel});
  end

  always_comb begin
    case (state_r)
      S_HEAD:  slot_raddr = head_rd_r;
      S_CMP:   slot_raddr = nxt_rd_r;
      default: slot_raddr = cur_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    done       = 1'b0;
    res_ok     = 1'b0;
    res_found  = '0;
    head_we    = 1'b0;
    head_waddr = bkt_r;
    head_wdata = alloc_slot;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = alloc_slot;
    nxt_we     = 1'b0;
    nxt_waddr  = alloc_slot;
    nxt_wdata  = head_r;
    case (state_r)
      S_IDLE: begin
        if (do_clear) begin
          count_nxt = '0;
          done      = 1'b1;
          res_ok    = 1'b1;
        end else if (start) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = head_valid_r[bkt_r] ? S_CMP : S_MISS;
      end
      S_CMP: begin
        if (match) begin
          state_nxt = S_IDLE;
          done      = 1'b1;
          res_ok    = 1'b1;
          case (cmd_r)
            CMD_SET: begin
              val_we    = 1'b1;
              val_waddr = cur_r;
            end
            CMD_GET: begin
              res_found = val_rd_r;
            end
            CMD_REMOVE: begin
              if (has_prev_r) begin
                nxt_we    = 1'b1;
                nxt_waddr = prev_r;
                nxt_wdata = nxt_rd_r;
              end else begin
                head_we    = 1'b1;
                head_wdata = nxt_rd_r;
              end
              if (count_r != '0) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (!nv_cur) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (cmd_r == CMD_SET) begin
          state_nxt = S_GRP;
        end else begin
          state_nxt = S_IDLE;
          done      = 1'b1;
        end
      end
      S_GRP: begin
        if (grp_any) begin
          state_nxt = S_ALLOC;
        end else begin
          // Store full: nothing changes.
          state_nxt = S_IDLE;
          done      = 1'b1;
        end
      end
      S_ALLOC: begin
        state_nxt = S_IDLE;
        done      = 1'b1;
        res_ok    = 1'b1;
        head_we   = 1'b1;
        key_we    = 1'b1;
        val_we    = 1'b1;
        nxt_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    head_rd_r <= head_mem[req.bucket];
    key_rd_r  <= key_mem[slot_raddr];
    val_rd_r  <= val_mem[slot_raddr];
    nxt_rd_r  <= nxt_mem[slot_raddr];
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (key_we) begin
      key_mem[alloc_slot] <= key_r;
    end
    if (val_we) begin
      val_mem[val_waddr] <= value_r;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= req.cmd;
      key_r   <= req.key;
      value_r <= req.value;
      bkt_r   <= req.bucket;
    end
    if (state_r == S_HEAD) begin
      head_r     <= head_rd_r;
      head_v_r   <= head_valid_r[bkt_r];
      cur_r      <= head_rd_r;
      has_prev_r <= 1'b0;
    end
    if (state_r == S_CMP && !match) begin
      prev_r     <= cur_r;
      has_prev_r <= 1'b1;
      cur_r      <= nxt_rd_r;
    end
    if (state_r == S_GRP) begin
      grp_r <= grp_sel;
    end
    if (done) begin
      out_ok_r    <= res_ok;
      out_found_r <= res_found;
      out_count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      head_valid_r <= '0;
      slot_used_r  <= '0;
      next_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (do_clear) begin
        head_valid_r <= '0;
        slot_used_r  <= '0;
        next_valid_r <= '0;
      end
      if (state_r == S_CMP && match && cmd_r == CMD_REMOVE) begin
        if (has_prev_r) begin
          next_valid_r[prev_r] <= nv_cur;
        end else begin
          head_valid_r[bkt_r] <= nv_cur;
        end
        slot_used_r[cur_r]  <= 1'b0;
        next_valid_r[cur_r] <= 1'b0;
      end
      if (state_r == S_ALLOC) begin
        head_valid_r[bkt_r]      <= 1'b1;
        slot_used_r[alloc_slot]  <= 1'b1;
        next_valid_r[alloc_slot] <= head_v_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_value = 32'(out_found_r);
  assign out_count       = 9'(out_count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("stored count above capacity");

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !out_valid_r) else $error("command started over a pending result");

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r) else $error("finished command produced no result");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    do_clear |=> (head_valid_r == '0) && (count_r == '0))
    else $error("clear left entries behind");

endmodule

[hw/rtl/chained_hash_map_top.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Key-value map with separate chaining over 64 buckets and 256 entry slots.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_cmd (set, get, remove, clear),
// in_key and in_value. A transaction is taken when in_valid is high and
// in_stall is low; a two-entry queue stands behind the input port.
// Output channel: out_valid/out_stall with out_ok, out_found_value and
// out_count; every command gives exactly one result, in order.
// Commands run one at a time in the chain engine. Clear finishes straight
// from idle; get, remove or a set that updates read the bucket head and
// then compare the chain entries in turn (one memory read per entry), a
// miss passes through a miss state and a set that inserts adds the
// two-step free-slot search. A new command starts only once the result
// register is empty.
// Reset (rst_n low, synchronous) empties all buckets and slots at once and
// sets the count to zero; no sweep is needed.
// While out_stall holds, the result stays in the output register, the engine
// waits and the queue fills, after which in_stall rises.
// ----------------------------------------------------------------------------
module chained_hash_map_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [31:0] out_found_value,
  output logic [8:0]  out_count
);
  import chm_pkg::*;

  req_t  req;
  logic  req_valid;
  logic  req_pop;

  chm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_key    (in_key),
    .in_value  (in_value),
    .req       (req),
    .req_valid (req_valid),
    .req_pop   (req_pop)
  );

  chm_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .req_valid       (req_valid),
    .req_pop         (req_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_found_value (out_found_value),
    .out_count       (out_count)
  );

endmodule

[dv/tb_chained_hash_map_top.sv]
// ----------------------------------------------------------------------------
// tb_chained_hash_map_top
// Self-checking bench for the chained hash map: a behavioral map predicts
// ok, found value and count for every command; random idles on both sides.
// ----------------------------------------------------------------------------
module tb_chained_hash_map_top;
  import chm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [31:0] out_found_value;
  logic [8:0]  out_count;

  typedef struct {
    logic        ok;
    logic [31:0] found_value;
    logic [8:0]  count;
  } map_result_t;

  // Predicted map: slots in an array, each bucket chain as a queue of slots
  // ordered from head to tail.
  logic        pm_used [CAPACITY];
  logic [31:0] pm_key  [CAPACITY];
  logic [31:0] pm_val  [CAPACITY];
  int          pm_chain [BUCKETS][$];
  int          pm_count;

  map_result_t pending_results[$];
  int          mismatches;
  bit          rx_idle_enable;

  // Small key pool so that hits, collisions and long chains are common.
  logic [31:0] key_pool[$];

  chained_hash_map_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ok(out_ok), .out_found_value(out_found_value), .out_count(out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("chained_hash_map_top regression: fail");
    $finish;
  end

  function automatic map_result_t predict_map(cmd_t cmd, logic [31:0] key,
                                              logic [31:0] value);
    map_result_t r;
    int b;
    int pos;
    int s;
    r.ok = 1'b0;
    r.found_value = '0;
    b = int'(key % BUCKETS);
    pos = -1;
    for (int i = 0; i < pm_chain[b].size(); i++)
      if (pos < 0 && pm_key[pm_chain[b][i]] == key) pos = i;
    case (cmd)
      CMD_SET: begin
        if (pos >= 0) begin
          pm_val[pm_chain[b][pos]] = value;
          r.ok = 1'b1;
        end else begin
          s = -1;
          for (int i = 0; i < CAPACITY; i++)
            if (s < 0 && !pm_used[i]) s = i;
          if (s >= 0) begin
            pm_used[s] = 1'b1;
            pm_key[s] = key;
            pm_val[s] = value;
            pm_chain[b].push_front(s);
            pm_count++;
            r.ok = 1'b1;
          end
        end
      end
      CMD_GET: begin
        if (pos >= 0) begin
          r.ok = 1'b1;
          r.found_value = pm_val[pm_chain[b][pos]];
        end
      end
      CMD_REMOVE: begin
        if (pos >= 0) begin
          pm_used[pm_chain[b][pos]] = 1'b0;
          pm_chain[b].delete(pos);
          pm_count--;
          r.ok = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < BUCKETS; i++) pm_chain[i].delete();
        for (int i = 0; i < CAPACITY; i++) pm_used[i] = 1'b0;
        pm_count = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count = 9'(pm_count);
    return r;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  // Sends one transaction; the prediction is queued as it is accepted.
  task automatic send_cmd(cmd_t cmd, logic [31:0] key, logic [31:0] value,
                          bit gaps = 1'b1);
    int n;
    n = gaps ? idle_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_map(cmd, key, value));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    map_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_ok), 32'h0);
      end else begin
        e = pending_results.pop_front();
        if (out_ok !== e.ok) report_mismatch("ok", 32'(out_ok), 32'(e.ok));
        if (out_found_value !== e.found_value)
          report_mismatch("found_value", out_found_value, e.found_value);
        if (out_count !== e.count)
          report_mismatch("count", 32'(out_count), 32'(e.count));
      end
    end
  end

  // Receiver stall pattern.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_idle_enable && $urandom_range(0, 3) == 0) begin
        n = idle_len();
        out_stall <= 1'b1;
        repeat (n + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 9) < 8)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_cmd(CMD_GET, 32'h0, 32'h0);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_SET, 32'h0, 32'hFFFF_FFFF);
    send_cmd(CMD_SET, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_SET, 32'h40, 32'hA5A5_A5A5);       // collides with key 0
    send_cmd(CMD_SET, 32'h8000_0000, 32'h5A5A_5A5A); // also bucket 0
    send_cmd(CMD_GET, 32'h0, 32'h1234);
    send_cmd(CMD_GET, 32'h40, 32'h0);
    send_cmd(CMD_GET, 32'h80, 32'h0);               // absent, same chain
    send_cmd(CMD_SET, 32'h40, 32'h1111_2222);       // update in place
    send_cmd(CMD_REMOVE, 32'h40, 32'h0);            // middle of chain
    send_cmd(CMD_REMOVE, 32'h8000_0000, 32'h0);     // head of chain
    send_cmd(CMD_GET, 32'h0, 32'h0);
    send_cmd(CMD_SET, 32'h7F, 32'h0);               // reuses lowest free slot
    send_cmd(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_GET, 32'h0, 32'h0);
    send_cmd(CMD_REMOVE, 32'h0, 32'h0);
    drain_results();
  endtask

  // Fill the store, hit the full case, then empty part of it.
  task automatic test_store_full();
    logic [31:0] k;
    for (int i = 0; i < CAPACITY; i++) begin
      k = $urandom();
      key_pool.push_back(k);
      send_cmd(CMD_SET, k, $urandom(), 1'b0);
    end
    send_cmd(CMD_SET, 32'hDEAD_BEEF ^ key_pool[0] ^ 32'h1, $urandom());
    send_cmd(CMD_SET, key_pool[3], $urandom());     // update still works when full
    for (int i = 0; i < 40; i++)
      send_cmd(CMD_REMOVE, key_pool[$urandom_range(0, CAPACITY - 1)], $urandom());
    send_cmd(CMD_SET, $urandom(), $urandom());
    drain_results();
    send_cmd(CMD_CLEAR, $urandom(), $urandom());
    key_pool.delete();
  endtask

  task automatic test_random();
    int p;
    for (int i = 0; i < 8; i++) key_pool.push_back($urandom());
    for (int i = 0; i < 8; i++) key_pool.push_back(32'($urandom_range(0, 7)) << 6);
    for (int i = 0; i < 520; i++) begin
      if (i == 260) drain_results();
      if (i % 64 == 0) key_pool.push_back($urandom());
      p = $urandom_range(0, 99);
      if (p < 45)      send_cmd(CMD_SET, pick_key(), $urandom());
      else if (p < 75) send_cmd(CMD_GET, pick_key(), $urandom());
      else if (p < 98) send_cmd(CMD_REMOVE, pick_key(), $urandom());
      else             send_cmd(CMD_CLEAR, $urandom(), $urandom());
    end
    drain_results();
  endtask

  initial begin
    int wait_cycles;
    mismatches = 0;
    rx_idle_enable = 1'b0;
    for (int i = 0; i < CAPACITY; i++) pm_used[i] = 1'b0;
    pm_count = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_cmd   = CMD_SET;
    in_key   = '0;
    in_value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    rx_idle_enable = 1'b1;
    test_store_full();
    test_random();
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("chained_hash_map_top regression: pass");
    else
      $display("chained_hash_map_top regression: fail");
    $finish;
  end

endmodule
